FILE: sv/dmtlb_pkg.sv
// ----------------------------------------------------------------------------
// dmtlb_pkg: shared types and codes of the direct-mapped TLB
// Field widths, operation/status/kind codes, slot and decision records.
// ----------------------------------------------------------------------------
package dmtlb_pkg;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF   = 256;
   localparam int PAGE_BITS_DEF = 12;
   localparam int ADDR_BITS_DEF = 48;

   // Fixed field widths
   localparam int VA_W          = 48;
   localparam int SPACE_W       = 16;
   localparam int GEN_W         = 32;
   localparam int FRAME_W       = 36;
   localparam int FILL_PAGE_W   = 36;
   localparam int PERMS_W       = 8;
   localparam int CNT_W         = 32;
   localparam int NUM_EV        = 8;
   localparam int RIGHTS_W      = 3;
   localparam int MIN_PAGE_BITS = 10;
   // widest page number that a slot tag has to hold
   localparam int TAG_PAGE_W    = VA_W - MIN_PAGE_BITS;

   // Operations
   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_FILL   = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;
   localparam logic [1:0] FUNC_NOP    = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_RETRY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // Access kinds
   localparam logic [1:0] KIND_FETCH   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_WRITE   = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // Event counter slots
   localparam int EV_FETCH_HIT  = 0;
   localparam int EV_READ_HIT   = 1;
   localparam int EV_WRITE_HIT  = 2;
   localparam int EV_FETCH_MISS = 3;
   localparam int EV_READ_MISS  = 4;
   localparam int EV_WRITE_MISS = 5;
   localparam int EV_FAULT      = 6;
   localparam int EV_FLUSH      = 7;

   typedef logic [NUM_EV-1:0][CNT_W-1:0] counts_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [SPACE_W-1:0]     space_id;
      logic [VA_W-1:0]        guest_addr;
      logic [1:0]             access_kind;
      logic [GEN_W-1:0]       req_generation;
      logic [GEN_W-1:0]       cur_generation;
      logic                   gen_stable;
      logic [FILL_PAGE_W-1:0] fill_page;
      logic [FRAME_W-1:0]     fill_frame;
      logic [PERMS_W-1:0]     fill_perms;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VA_W-1:0]    host_addr;
      logic [PERMS_W-1:0] perms_out;
      counts_type         counts;
   } rsp_item_type;

   typedef struct packed {
      logic [SPACE_W-1:0]    space;
      logic [TAG_PAGE_W-1:0] page;
      logic [FRAME_W-1:0]    frame;
      logic [GEN_W-1:0]      gen;
      logic [PERMS_W-1:0]    perms;
      logic [RIGHTS_W-1:0]   rights;
   } slot_type;

   typedef struct packed {
      logic               valid;
      logic [SPACE_W-1:0] space;
      logic [GEN_W-1:0]   gen;
   } active_type;

   // Outcome of one operation, applied when the item leaves the work stage
   typedef struct packed {
      logic [1:0]         status;
      logic [VA_W-1:0]    host_addr;
      logic [PERMS_W-1:0] perms;
      logic               clear_all;
      logic               act_load;
      active_type         act_next;
      logic [NUM_EV-1:0]  ev_inc;
      logic               wr_en;
      slot_type           wr_slot;
   } decision_type;

endpackage

FILE: sv/dmtlb_channels.sv
// ----------------------------------------------------------------------------
// dmtlb channels: request and response valid/ready interfaces
// One transfer per edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface dmtlb_req_if;
   import dmtlb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             func;
   logic [SPACE_W-1:0]     space_id;
   logic [VA_W-1:0]        guest_addr;
   logic [1:0]             access_kind;
   logic [GEN_W-1:0]       req_generation;
   logic [GEN_W-1:0]       cur_generation;
   logic                   gen_stable;
   logic [FILL_PAGE_W-1:0] fill_page;
   logic [FRAME_W-1:0]     fill_frame;
   logic [PERMS_W-1:0]     fill_perms;

   modport source (
      output valid, func, space_id, guest_addr, access_kind, req_generation,
             cur_generation, gen_stable, fill_page, fill_frame, fill_perms,
      input  ready
   );
   modport sink (
      input  valid, func, space_id, guest_addr, access_kind, req_generation,
             cur_generation, gen_stable, fill_page, fill_frame, fill_perms,
      output ready
   );
endinterface

interface dmtlb_rsp_if;
   import dmtlb_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [VA_W-1:0]    host_addr;
   logic [PERMS_W-1:0] perms_out;
   logic [CNT_W-1:0]   fetch_hit_count;
   logic [CNT_W-1:0]   read_hit_count;
   logic [CNT_W-1:0]   write_hit_count;
   logic [CNT_W-1:0]   fetch_miss_count;
   logic [CNT_W-1:0]   read_miss_count;
   logic [CNT_W-1:0]   write_miss_count;
   logic [CNT_W-1:0]   fault_count;
   logic [CNT_W-1:0]   flush_count;

   modport source (
      output valid, status, host_addr, perms_out, fetch_hit_count, read_hit_count,
             write_hit_count, fetch_miss_count, read_miss_count, write_miss_count,
             fault_count, flush_count,
      input  ready
   );
   modport sink (
      input  valid, status, host_addr, perms_out, fetch_hit_count, read_hit_count,
             write_hit_count, fetch_miss_count, read_miss_count, write_miss_count,
             fault_count, flush_count,
      output ready
   );
endinterface

FILE: sv/dmtlb_slot_mem.sv
// ----------------------------------------------------------------------------
// dmtlb_slot_mem: slot payload store
// One write port, one registered read port, write-to-read forwarding.
// ----------------------------------------------------------------------------
module dmtlb_slot_mem #(
   parameter int ENTRIES = dmtlb_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_idx,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  dmtlb_pkg::slot_type        wr_data,
   output dmtlb_pkg::slot_type        rd_data
);
   import dmtlb_pkg::*;

   slot_type mem [ENTRIES];
   slot_type rd_ff;
   slot_type fwd_ff;
   logic     fwd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_ff  <= mem[rd_idx];
         fwd_ff <= wr_data;
      end
   end

   // same-edge write to the slot being read wins
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_sel_ff <= wr_en && (wr_idx == rd_idx);
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_ff : rd_ff;

endmodule

FILE: sv/dmtlb_decide.sv
// ----------------------------------------------------------------------------
// dmtlb_decide: lookup / fill / flush decision
// Combinational outcome of one item from its slot and the active pair.
// ----------------------------------------------------------------------------
module dmtlb_decide #(
   parameter int PAGE_BITS = dmtlb_pkg::PAGE_BITS_DEF,
   parameter int ADDR_BITS = dmtlb_pkg::ADDR_BITS_DEF
) (
   input  dmtlb_pkg::req_item_type item,
   input  dmtlb_pkg::slot_type     slot,
   input  logic                    slot_valid,
   input  dmtlb_pkg::active_type   active,
   output dmtlb_pkg::decision_type dec
);
   import dmtlb_pkg::*;

   localparam int EFF_A   = (ADDR_BITS < VA_W) ? ADDR_BITS : VA_W;
   localparam int PAGE_W  = EFF_A - PAGE_BITS;
   localparam int FPAGE_R = ADDR_BITS - PAGE_BITS;
   localparam int FPAGE_W = (FPAGE_R < FILL_PAGE_W) ? FPAGE_R : FILL_PAGE_W;
   localparam logic [FILL_PAGE_W-1:0] FPAGE_MASK =
      FILL_PAGE_W'({FPAGE_W{1'b1}});
   localparam logic [VA_W-1:0] HOST_MASK = VA_W'({EFF_A{1'b1}});

   logic [PAGE_W-1:0]      page;
   logic [TAG_PAGE_W-1:0]  page_ext;
   logic [TAG_PAGE_W-1:0]  fpage_ext;
   logic [PAGE_BITS-1:0]   offset;
   logic                   gen_change;
   logic                   retry;
   logic                   live;
   logic                   tag_hit;
   logic                   fill_match;
   logic                   fill_bad;
   logic                   right_ok;
   logic [3:0]             rights4;
   logic [RIGHTS_W-1:0]    kind_bit;
   logic [NUM_EV-1:0]      hit_ev;
   logic [NUM_EV-1:0]      miss_ev;
   logic [VA_W-1:0]        host;

   assign page      = item.guest_addr[PAGE_BITS +: PAGE_W];
   assign page_ext  = TAG_PAGE_W'(page);
   assign fpage_ext = TAG_PAGE_W'(item.fill_page & FPAGE_MASK);
   assign offset    = item.guest_addr[PAGE_BITS-1:0];

   assign gen_change = !active.valid || (active.space != item.space_id) ||
                       (active.gen != item.cur_generation);
   assign retry      = (item.req_generation != item.cur_generation) ||
                       !item.gen_stable;
   // a generation change wipes the store before the slot is looked at
   assign live       = slot_valid && !gen_change;

   assign tag_hit    = live && (slot.space == item.space_id) &&
                       (slot.page == page_ext) && (slot.gen == item.req_generation);
   assign fill_match = live && (slot.space == item.space_id) &&
                       (slot.page == fpage_ext) && (slot.frame == item.fill_frame) &&
                       (slot.gen == item.req_generation);
   assign fill_bad   = (item.space_id == '0) || (item.fill_frame == '0) ||
                       (page_ext != fpage_ext) || (item.access_kind == KIND_UNKNOWN);

   assign rights4  = {1'b0, slot.rights};
   assign right_ok = (item.access_kind != KIND_UNKNOWN) && rights4[item.access_kind];
   assign kind_bit = RIGHTS_W'(4'b0001 << item.access_kind);

   assign host = (((VA_W'(slot.frame)) << PAGE_BITS) | VA_W'(offset)) & HOST_MASK;

   always_comb begin
      hit_ev  = '0;
      miss_ev = '0;
      case (item.access_kind)
         KIND_FETCH: begin
            hit_ev[EV_FETCH_HIT]   = 1'b1;
            miss_ev[EV_FETCH_MISS] = 1'b1;
         end
         KIND_READ: begin
            hit_ev[EV_READ_HIT]   = 1'b1;
            miss_ev[EV_READ_MISS] = 1'b1;
         end
         KIND_WRITE: begin
            hit_ev[EV_WRITE_HIT]   = 1'b1;
            miss_ev[EV_WRITE_MISS] = 1'b1;
         end
         default: begin
            miss_ev[EV_FAULT] = 1'b1;
         end
      endcase
   end

   always_comb begin
      dec          = '0;
      dec.status   = ST_OK;
      dec.act_next = active;
      dec.wr_slot  = slot;

      case (item.func)
         FUNC_LOOKUP: begin
            if (item.space_id == '0) begin
               dec.status           = ST_INVALID;
               dec.ev_inc[EV_FAULT] = 1'b1;
            end else begin
               if (gen_change) begin
                  dec.clear_all        = 1'b1;
                  dec.act_load         = 1'b1;
                  dec.act_next         = '{valid: 1'b1, space: item.space_id,
                                           gen: item.cur_generation};
                  dec.ev_inc[EV_FLUSH] = 1'b1;
               end
               if (retry) begin
                  dec.status = ST_RETRY;
                  dec.ev_inc = dec.ev_inc | miss_ev;
               end else if (tag_hit && right_ok) begin
                  dec.ev_inc    = dec.ev_inc | hit_ev;
                  dec.host_addr = host;
                  dec.perms     = slot.perms;
               end else begin
                  dec.status = ST_NOTFOUND;
                  dec.ev_inc = dec.ev_inc | miss_ev;
               end
            end
         end
         FUNC_FILL: begin
            if (fill_bad) begin
               dec.status = ST_INVALID;
            end else begin
               if (gen_change) begin
                  dec.clear_all        = 1'b1;
                  dec.act_load         = 1'b1;
                  dec.act_next         = '{valid: 1'b1, space: item.space_id,
                                           gen: item.cur_generation};
                  dec.ev_inc[EV_FLUSH] = 1'b1;
               end
               if (retry) begin
                  dec.status = ST_RETRY;
               end else begin
                  dec.wr_en = 1'b1;
                  if (!fill_match) begin
                     dec.wr_slot.space  = item.space_id;
                     dec.wr_slot.page   = fpage_ext;
                     dec.wr_slot.frame  = item.fill_frame;
                     dec.wr_slot.gen    = item.req_generation;
                     dec.wr_slot.rights = '0;
                  end
                  dec.wr_slot.perms  = item.fill_perms;
                  dec.wr_slot.rights = dec.wr_slot.rights | kind_bit;
               end
            end
         end
         FUNC_FLUSH: begin
            dec.clear_all        = 1'b1;
            dec.act_load         = 1'b1;
            dec.act_next         = '0;
            dec.ev_inc[EV_FLUSH] = 1'b1;
         end
         default: begin
            dec.status = ST_INVALID;
         end
      endcase
   end

endmodule

FILE: sv/dmtlb_counters.sv
// ----------------------------------------------------------------------------
// dmtlb_counters: event counters
// Eight wrapping 32-bit counters; exposes the post-increment values.
// ----------------------------------------------------------------------------
module dmtlb_counters (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [dmtlb_pkg::NUM_EV-1:0]   inc,
   output dmtlb_pkg::counts_type          cnt_next
);
   import dmtlb_pkg::*;

   counts_type cnt_ff;
   counts_type cnt_in;

   always_comb begin
      for (int i = 0; i < NUM_EV; i++) begin
         cnt_in[i] = cnt_ff[i] + CNT_W'(inc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (en) begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt_next = cnt_in;

endmodule

FILE: sv/direct_mapped_tlb_with_generation_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_tlb_with_generation_top: direct-mapped TLB with generation tags
// Path: a request passes the input/slot read register, then the response
//   register, and is held there while the response stalls.
// Throughput: one request per cycle while the response sink keeps up;
//   the single slot-store read port and the response register set that figure.
// Reset (synchronous): clears all slot valid bits, the active space/generation,
//   the event counters and both pipeline stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
module direct_mapped_tlb_with_generation_top #(
   parameter int ENTRIES   = dmtlb_pkg::ENTRIES_DEF,   // power of two
   parameter int PAGE_BITS = dmtlb_pkg::PAGE_BITS_DEF,
   parameter int ADDR_BITS = dmtlb_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dmtlb_req_if.sink   req_chan,
   dmtlb_rsp_if.source rsp_chan
);
   import dmtlb_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   // ---- work stage: request plus registered slot read ----
   req_item_type  req_item;
   req_item_type  s1_ff;
   logic          s1_valid_ff;
   logic          s1_adv;
   logic          req_xfer;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] s1_idx;

   // ---- architectural state ----
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   active_type         active_ff;

   // ---- response stage ----
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   slot_type     slot_rd;
   decision_type dec;
   counts_type   cnt_next;

   assign req_item = '{
      func:           req_chan.func,
      space_id:       req_chan.space_id,
      guest_addr:     req_chan.guest_addr,
      access_kind:    req_chan.access_kind,
      req_generation: req_chan.req_generation,
      cur_generation: req_chan.cur_generation,
      gen_stable:     req_chan.gen_stable,
      fill_page:      req_chan.fill_page,
      fill_frame:     req_chan.fill_frame,
      fill_perms:     req_chan.fill_perms
   };

   // Slot index is the low page-number bits.
   assign rd_idx = req_chan.guest_addr[PAGE_BITS +: IDX_W];
   assign s1_idx = s1_ff.guest_addr[PAGE_BITS +: IDX_W];

   // The work stage retires into the response register whenever that register
   // is empty or being drained; a new request enters behind it in the same edge.
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= req_item;
      end
   end

   // Slot payload store. The retiring item writes at the same edge the next
   // request reads; the store forwards that write to the reader.
   dmtlb_slot_mem #(
      .ENTRIES (ENTRIES)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_idx  (rd_idx),
      .wr_en   (s1_adv && dec.wr_en),
      .wr_idx  (s1_idx),
      .wr_data (dec.wr_slot),
      .rd_data (slot_rd)
   );

   dmtlb_decide #(
      .PAGE_BITS (PAGE_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_decide (
      .item       (s1_ff),
      .slot       (slot_rd),
      .slot_valid (valid_ff[s1_idx]),
      .active     (active_ff),
      .dec        (dec)
   );

   dmtlb_counters u_counters (
      .clock    (clock),
      .reset    (reset),
      .en       (s1_adv),
      .inc      (dec.ev_inc),
      .cnt_next (cnt_next)
   );

   // Valid bits live in flops so a flush or generation change clears them all
   // together; a fill in the same step then sets its own slot.
   always_comb begin
      valid_in = dec.clear_all ? '0 : valid_ff;
      if (dec.wr_en) begin
         valid_in[s1_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= '0;
      end else if (s1_adv) begin
         valid_ff <= valid_in;
         if (dec.act_load) begin
            active_ff <= dec.act_next;
         end
      end
   end

   // Response register: holds a finished result while the sink stalls.
   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff.status    <= dec.status;
         rsp_ff.host_addr <= dec.host_addr;
         rsp_ff.perms_out <= dec.perms;
         rsp_ff.counts    <= cnt_next;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_ff.status;
   assign rsp_chan.host_addr        = rsp_ff.host_addr;
   assign rsp_chan.perms_out        = rsp_ff.perms_out;
   assign rsp_chan.fetch_hit_count  = rsp_ff.counts[EV_FETCH_HIT];
   assign rsp_chan.read_hit_count   = rsp_ff.counts[EV_READ_HIT];
   assign rsp_chan.write_hit_count  = rsp_ff.counts[EV_WRITE_HIT];
   assign rsp_chan.fetch_miss_count = rsp_ff.counts[EV_FETCH_MISS];
   assign rsp_chan.read_miss_count  = rsp_ff.counts[EV_READ_MISS];
   assign rsp_chan.write_miss_count = rsp_ff.counts[EV_WRITE_MISS];
   assign rsp_chan.fault_count      = rsp_ff.counts[EV_FAULT];
   assign rsp_chan.flush_count      = rsp_ff.counts[EV_FLUSH];

endmodule

FILE: sv/dmtlb_checker.sv
// ----------------------------------------------------------------------------
// dmtlb_checker: port-level checks of the TLB
// Reset, ready, response hold and failed-result checks; bound to the top.
// ----------------------------------------------------------------------------
module dmtlb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    status,
   input logic [dmtlb_pkg::VA_W-1:0]    host_addr,
   input logic [dmtlb_pkg::PERMS_W-1:0] perms_out,
   input logic [dmtlb_pkg::CNT_W-1:0]   flush_count
);
   import dmtlb_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response stage");

   a_no_data_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |-> (host_addr == '0) && (perms_out == '0))
      else $error("translation data on a failed result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
         $stable(host_addr) && $stable(flush_count))
      else $error("response changed while stalled");

endmodule

bind direct_mapped_tlb_with_generation_top dmtlb_checker u_dmtlb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .status      (rsp_chan.status),
   .host_addr   (rsp_chan.host_addr),
   .perms_out   (rsp_chan.perms_out),
   .flush_count (rsp_chan.flush_count)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: direct-mapped TLB with generation tags
// Drives lookups, fills and flushes through the request channel. A short table
// of directed operations comes first, then random traffic built around a small
// pool of pages so that fills are later hit by lookups. Each response is checked
// field by field against an in-bench model of the translation store.
// ----------------------------------------------------------------------------
module testbench;
   import dmtlb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Geometry of the instance under test (default parameters)
   localparam int TLB_ENTRIES = ENTRIES_DEF;
   localparam int OFFSET_W    = PAGE_BITS_DEF;
   localparam int VPN_W       = VA_W - OFFSET_W;

   // Random traffic shape
   localparam int RANDOM_OPS  = 1825;
   localparam int POOL        = 24;
   // stretch of transfers sent back to back, no sender gaps
   localparam int CALM_FROM   = 700;
   localparam int CALM_TO     = 1000;

   // Directed contexts
   localparam logic [SPACE_W-1:0] SPACE_A = 16'h0001;
   localparam logic [SPACE_W-1:0] SPACE_Z = 16'hFFFF;
   localparam logic [GEN_W-1:0]   GEN_A   = 32'd5;
   localparam logic [GEN_W-1:0]   GEN_Z   = 32'hFFFF_FFFF;

   typedef struct {
      req_item_type       op;
      bit                 typed;     // status/host/perms written in by hand
      logic [1:0]         status;
      logic [VA_W-1:0]    host;
      logic [PERMS_W-1:0] perms;
   } directed_row_t;

   logic clock;
   logic reset;

   dmtlb_req_if req_chan ();
   dmtlb_rsp_if rsp_chan ();

   direct_mapped_tlb_with_generation_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // -------------------------------------------------------------------------
   // Translation store model: its own copy of slots, active pair and counters
   // -------------------------------------------------------------------------
   bit           slot_live [TLB_ENTRIES];
   slot_type     slot_copy [TLB_ENTRIES];
   active_type   act_pair    = '0;
   counts_type   event_tally = '0;

   rsp_item_type  pending_rsp [$];   // responses still owed by the block
   directed_row_t directed_rows [$];
   int unsigned   mismatches  = 0;
   int unsigned   ops_sent    = 0;
   int unsigned   burst_left  = 0;
   int unsigned   sink_cycle  = 0;

   // Random traffic context: the space/generation most items run under
   logic [SPACE_W-1:0]     ctx_space = SPACE_A;
   logic [GEN_W-1:0]       ctx_gen   = 32'd1;
   logic [VPN_W-1:0]       pool_page  [POOL];
   logic [FRAME_W-1:0]     pool_frame [POOL];

   string counter_name [NUM_EV] = '{"fetch_hit_count", "read_hit_count",
      "write_hit_count", "fetch_miss_count", "read_miss_count",
      "write_miss_count", "fault_count", "flush_count"};

   // Whole-store flush: valid bits and active pair cleared, one flush counted
   function automatic void wipe_slots();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      act_pair = '0;
      event_tally[EV_FLUSH] = event_tally[EV_FLUSH] + 1'b1;
   endfunction

   // A new space or current generation flushes before the op proceeds
   function automatic void adopt_context(logic [SPACE_W-1:0] space,
                                         logic [GEN_W-1:0] gen);
      if (!act_pair.valid || act_pair.space != space || act_pair.gen != gen) begin
         wipe_slots();
         act_pair.valid = 1'b1;
         act_pair.space = space;
         act_pair.gen   = gen;
      end
   endfunction

   // Misses and retries count per kind; the unknown kind counts as a fault
   function automatic void tally_miss(logic [1:0] kind);
      if (kind == KIND_UNKNOWN)
         event_tally[EV_FAULT] = event_tally[EV_FAULT] + 1'b1;
      else
         event_tally[EV_FETCH_MISS + int'(kind)] =
            event_tally[EV_FETCH_MISS + int'(kind)] + 1'b1;
   endfunction

   function automatic rsp_item_type predict_translation(req_item_type op);
      rsp_item_type    res;
      logic [VPN_W-1:0] vpn;
      int unsigned     idx;
      bit              ctx_ok;
      bit              same_entry;
      res = '0;
      res.status = ST_OK;
      vpn    = op.guest_addr[VA_W-1:OFFSET_W];
      idx    = vpn % TLB_ENTRIES;
      ctx_ok = (op.req_generation == op.cur_generation) && op.gen_stable;
      case (op.func)
         FUNC_LOOKUP: begin
            if (op.space_id == '0) begin
               event_tally[EV_FAULT] = event_tally[EV_FAULT] + 1'b1;
               res.status = ST_INVALID;
            end else begin
               adopt_context(op.space_id, op.cur_generation);
               if (!ctx_ok) begin
                  tally_miss(op.access_kind);
                  res.status = ST_RETRY;
               end else if (op.access_kind != KIND_UNKNOWN && slot_live[idx] &&
                            slot_copy[idx].space == op.space_id &&
                            slot_copy[idx].page == TAG_PAGE_W'(vpn) &&
                            slot_copy[idx].gen == op.req_generation &&
                            slot_copy[idx].rights[op.access_kind]) begin
                  event_tally[int'(op.access_kind)] =
                     event_tally[int'(op.access_kind)] + 1'b1;
                  res.host_addr = {slot_copy[idx].frame, op.guest_addr[OFFSET_W-1:0]};
                  res.perms_out = slot_copy[idx].perms;
               end else begin
                  tally_miss(op.access_kind);
                  res.status = ST_NOTFOUND;
               end
            end
         end
         FUNC_FILL: begin
            if (op.space_id == '0 || op.fill_frame == '0 || vpn != op.fill_page ||
                op.access_kind == KIND_UNKNOWN) begin
               res.status = ST_INVALID;
            end else begin
               adopt_context(op.space_id, op.cur_generation);
               if (!ctx_ok) begin
                  res.status = ST_RETRY;
               end else begin
                  same_entry = slot_live[idx] && slot_copy[idx].space == op.space_id &&
                               slot_copy[idx].page == TAG_PAGE_W'(op.fill_page) &&
                               slot_copy[idx].frame == op.fill_frame &&
                               slot_copy[idx].gen == op.req_generation;
                  if (!same_entry) begin
                     slot_live[idx]        = 1'b1;
                     slot_copy[idx].space  = op.space_id;
                     slot_copy[idx].page   = TAG_PAGE_W'(op.fill_page);
                     slot_copy[idx].frame  = op.fill_frame;
                     slot_copy[idx].gen    = op.req_generation;
                     slot_copy[idx].rights = '0;
                  end
                  slot_copy[idx].perms = op.fill_perms;
                  slot_copy[idx].rights[op.access_kind] = 1'b1;
               end
            end
         end
         FUNC_FLUSH: wipe_slots();
         default: res.status = ST_INVALID;
      endcase
      res.counts = event_tally;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit chance(int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic req_item_type tlb_op(
      logic [1:0] func, logic [SPACE_W-1:0] space, logic [VA_W-1:0] addr,
      logic [1:0] kind, logic [GEN_W-1:0] rgen, logic [GEN_W-1:0] cgen,
      logic stable, logic [FILL_PAGE_W-1:0] fpage, logic [FRAME_W-1:0] fframe,
      logic [PERMS_W-1:0] fperms);
      req_item_type op;
      op.func           = func;
      op.space_id       = space;
      op.guest_addr     = addr;
      op.access_kind    = kind;
      op.req_generation = rgen;
      op.cur_generation = cgen;
      op.gen_stable     = stable;
      op.fill_page      = fpage;
      op.fill_frame     = fframe;
      op.fill_perms     = fperms;
      return op;
   endfunction

   function automatic void add_row(req_item_type op, bit typed, logic [1:0] status,
                                   logic [VA_W-1:0] host, logic [PERMS_W-1:0] perms);
      directed_rows.push_back('{op, typed, status, host, perms});
   endfunction

   // One random op. Mostly well-formed fills and lookups under the current
   // context and on pooled pages, so hits, right upgrades and overwrites
   // happen; the rest are broken fills, flushes, no-ops and raw noise.
   function automatic req_item_type next_random_op();
      req_item_type      it;
      int unsigned       pick;
      int unsigned       slot;
      logic [VPN_W-1:0]  vpn;
      logic [FRAME_W-1:0] fresh;
      bit [255:0]        blob;
      // context drift: a change makes the next well-formed op flush the store
      case ($urandom_range(0, 299))
         0, 1, 2: ctx_gen   = ctx_gen + 1'b1;
         3:       ctx_gen   = GEN_Z;            // next bump wraps to zero
         4:       ctx_gen   = $urandom;
         5, 6:    ctx_space = SPACE_A;
         7:       ctx_space = SPACE_Z;
         8:       ctx_space = 16'($urandom_range(1, 65535));
         default: ;
      endcase
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL - 1);
      vpn  = pool_page[slot];
      it.func           = FUNC_FILL;
      it.space_id       = ctx_space;
      it.guest_addr     = {vpn, 12'($urandom)};
      it.access_kind    = 2'($urandom_range(0, 2));
      it.req_generation = ctx_gen;
      it.cur_generation = ctx_gen;
      it.gen_stable     = 1'b1;
      it.fill_page      = vpn;
      it.fill_frame     = pool_frame[slot];
      it.fill_perms     = 8'($urandom);
      if (pick < 36) begin
         // new frame for a pooled page: the slot gets overwritten
         if (chance(10)) begin
            do fresh = 36'(rand64()); while (fresh == '0);
            pool_frame[slot] = fresh;
            it.fill_frame    = fresh;
         end
         if (chance(5)) it.req_generation = $urandom;
         if (chance(5)) it.gen_stable = 1'b0;
      end else if (pick < 84) begin
         it.func       = FUNC_LOOKUP;
         it.fill_page  = 36'(rand64());
         it.fill_frame = 36'(rand64());
         if (chance(8)) it.guest_addr[VA_W-1:OFFSET_W] = 36'(rand64());
         if (chance(5)) it.access_kind = KIND_UNKNOWN;
         if (chance(5)) it.req_generation = $urandom;
         if (chance(5)) it.gen_stable = 1'b0;
         if (chance(2)) it.space_id = '0;
      end else if (pick < 90) begin
         // fill broken in exactly one way
         case ($urandom_range(0, 3))
            0:       it.space_id    = '0;
            1:       it.fill_frame  = '0;
            2:       it.fill_page   = vpn ^ (36'h1 << $urandom_range(0, 35));
            default: it.access_kind = KIND_UNKNOWN;
         endcase
      end else if (pick < 93) begin
         it.func = FUNC_FLUSH;
      end else if (pick < 94) begin
         it.func = FUNC_NOP;
      end else begin
         blob = {rand64(), rand64(), rand64(), rand64()};
         it   = blob[$bits(req_item_type)-1:0];
      end
      return it;
   endfunction

   // Present one op, wait for its transfer, log the owed response, then
   // decide whether the sender pauses before the next one.
   task automatic send_op(req_item_type op, bit typed, logic [1:0] status,
                          logic [VA_W-1:0] host, logic [PERMS_W-1:0] perms);
      rsp_item_type want;
      req_chan.valid          <= 1'b1;
      req_chan.func           <= op.func;
      req_chan.space_id       <= op.space_id;
      req_chan.guest_addr     <= op.guest_addr;
      req_chan.access_kind    <= op.access_kind;
      req_chan.req_generation <= op.req_generation;
      req_chan.cur_generation <= op.cur_generation;
      req_chan.gen_stable     <= op.gen_stable;
      req_chan.fill_page      <= op.fill_page;
      req_chan.fill_frame     <= op.fill_frame;
      req_chan.fill_perms     <= op.fill_perms;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = predict_translation(op);
      if (typed) begin
         want.status    = status;
         want.host_addr = host;
         want.perms_out = perms;
      end
      pending_rsp.push_back(want);
      ops_sent++;
      if (ops_sent >= CALM_FROM && ops_sent < CALM_TO) begin
         // back-to-back stretch
      end else if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Response side: ready follows a pattern of its own, cycling through
   // always ready, random, periodic short stalls and long stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      case ((sink_cycle / 250) % 4)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= ($urandom_range(0, 9) < 7);
         2:       rsp_chan.ready <= ((sink_cycle % 7) >= 3);
         default: rsp_chan.ready <= ((sink_cycle % 16) >= 12);
      endcase
   end

   // Every response transfer is held against the oldest owed response
   always @(posedge clock) begin : rsp_check
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status                = rsp_chan.status;
         seen.host_addr             = rsp_chan.host_addr;
         seen.perms_out             = rsp_chan.perms_out;
         seen.counts[EV_FETCH_HIT]  = rsp_chan.fetch_hit_count;
         seen.counts[EV_READ_HIT]   = rsp_chan.read_hit_count;
         seen.counts[EV_WRITE_HIT]  = rsp_chan.write_hit_count;
         seen.counts[EV_FETCH_MISS] = rsp_chan.fetch_miss_count;
         seen.counts[EV_READ_MISS]  = rsp_chan.read_miss_count;
         seen.counts[EV_WRITE_MISS] = rsp_chan.write_miss_count;
         seen.counts[EV_FAULT]      = rsp_chan.fault_count;
         seen.counts[EV_FLUSH]      = rsp_chan.flush_count;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response transfer with none owed, status %0h",
                     $time, seen.status);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (seen.status !== want.status)
               flag_mismatch("status", want.status, seen.status);
            if (seen.host_addr !== want.host_addr)
               flag_mismatch("host_addr", want.host_addr, seen.host_addr);
            if (seen.perms_out !== want.perms_out)
               flag_mismatch("perms_out", want.perms_out, seen.perms_out);
            for (int k = 0; k < NUM_EV; k++)
               if (seen.counts[k] !== want.counts[k])
                  flag_mismatch(counter_name[k], want.counts[k], seen.counts[k]);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      reset                   = 1'b1;
      rsp_chan.ready          = 1'b0;
      req_chan.valid          = 1'b0;
      req_chan.func           = FUNC_NOP;
      req_chan.space_id       = '0;
      req_chan.guest_addr     = '0;
      req_chan.access_kind    = KIND_FETCH;
      req_chan.req_generation = '0;
      req_chan.cur_generation = '0;
      req_chan.gen_stable     = 1'b0;
      req_chan.fill_page      = '0;
      req_chan.fill_frame     = '0;
      req_chan.fill_perms     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Page pool: pages spread over six shared slot indexes so different pages
      // fight over a slot, plus the lowest and highest page numbers.
      for (int p = 0; p < POOL; p++) begin
         pool_page[p] = {28'(rand64()), 8'(p % 6)};
         do pool_frame[p] = 36'(rand64()); while (pool_frame[p] == '0);
      end
      pool_page[POOL-2]  = '0;
      pool_page[POOL-1]  = '1;
      pool_frame[POOL-1] = '1;

      // Directed table. Space A / gen 5 holds page 1; space Z / gen all-ones
      // exercises the extremes and a slot shared by pages 0 and 0x100.
      // no space on lookup: fault, invalid
      add_row(tlb_op(FUNC_LOOKUP, '0, 48'h0, KIND_READ, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_INVALID, '0, '0);
      // unused selector
      add_row(tlb_op(FUNC_NOP, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     36'h1, 36'hABCDE, 8'hA5), 1'b1, ST_INVALID, '0, '0);
      // cold miss; first context flush
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     36'h1, 36'hABCDE, 8'hA5), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_OK, 48'hAB_CDE1_23, 8'hA5);
      // right not granted yet
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_WRITE, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      // matching fill adds the write right and new perms
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1000, KIND_WRITE, GEN_A, GEN_A, 1'b1,
                     36'h1, 36'hABCDE, 8'h5A), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1FFF, KIND_WRITE, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_OK, 48'hAB_CDEF_FF, 8'h5A);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1000, KIND_READ, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_OK, 48'hAB_CDE0_00, 8'h5A);
      // unknown kind never hits, counts a fault
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_UNKNOWN, GEN_A, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      // stale request generation, then unstable generation
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_READ, 32'd4, GEN_A, 1'b1,
                     '0, '0, '0), 1'b1, ST_RETRY, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b0,
                     '0, '0, '0), 1'b1, ST_RETRY, '0, '0);
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1123, KIND_FETCH, GEN_A, GEN_A, 1'b0,
                     36'h1, 36'hABCDE, 8'h11), 1'b1, ST_RETRY, '0, '0);
      // invalid fills: no frame, page mismatch, unknown kind, no space
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     36'h1, '0, 8'h11), 1'b1, ST_INVALID, '0, '0);
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     36'h2, 36'hABCDE, 8'h11), 1'b1, ST_INVALID, '0, '0);
      add_row(tlb_op(FUNC_FILL, SPACE_A, 48'h1123, KIND_UNKNOWN, GEN_A, GEN_A, 1'b1,
                     36'h1, 36'hABCDE, 8'h11), 1'b1, ST_INVALID, '0, '0);
      add_row(tlb_op(FUNC_FILL, '0, 48'h1123, KIND_READ, GEN_A, GEN_A, 1'b1,
                     36'h1, 36'hABCDE, 8'h11), 1'b1, ST_INVALID, '0, '0);
      // all-ones everywhere; space change flushes
      add_row(tlb_op(FUNC_FILL, SPACE_Z, '1, KIND_FETCH, GEN_Z, GEN_Z, 1'b1,
                     '1, '1, 8'hFF), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, '1, KIND_FETCH, GEN_Z, GEN_Z, 1'b1,
                     '0, '0, '0), 1'b1, ST_OK, '1, 8'hFF);
      // pages 0x100 and 0 share slot 0
      add_row(tlb_op(FUNC_FILL, SPACE_Z, 48'h10_0000, KIND_FETCH, GEN_Z, GEN_Z, 1'b1,
                     36'h100, 36'h1, 8'h00), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, 48'h0, KIND_FETCH, GEN_Z, GEN_Z, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      // new frame overwrites, dropping the fetch right
      add_row(tlb_op(FUNC_FILL, SPACE_Z, 48'h10_0000, KIND_READ, GEN_Z, GEN_Z, 1'b1,
                     36'h100, 36'h2, 8'h3C), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, 48'h10_0ABC, KIND_FETCH, GEN_Z, GEN_Z, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, 48'h10_0FFF, KIND_READ, GEN_Z, GEN_Z, 1'b1,
                     '0, '0, '0), 1'b1, ST_OK, 48'h2FFF, 8'h3C);
      add_row(tlb_op(FUNC_FLUSH, '0, '0, KIND_FETCH, '0, '0, 1'b0,
                     '0, '0, '0), 1'b1, ST_OK, '0, '0);
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, 48'h10_0FFF, KIND_READ, GEN_Z, GEN_Z, 1'b1,
                     '0, '0, '0), 1'b1, ST_NOTFOUND, '0, '0);
      // generation moves to zero: model decides
      add_row(tlb_op(FUNC_LOOKUP, SPACE_Z, 48'h10_0FFF, KIND_WRITE, '0, '0, 1'b1,
                     '0, '0, '0), 1'b0, ST_OK, '0, '0);

      @(posedge clock);
      foreach (directed_rows[n])
         send_op(directed_rows[n].op, directed_rows[n].typed, directed_rows[n].status,
                 directed_rows[n].host, directed_rows[n].perms);

      repeat (RANDOM_OPS) send_op(next_random_op(), 1'b0, ST_OK, '0, '0);

      // Drain: wait for every owed response, then wait on to catch strays
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
